[hdl/stt_pkg.sv]
// ---------------------------------------------------------------------------
// Tokeniser package
// Shared types, token kinds, error codes and scanner modes.
// ---------------------------------------------------------------------------
package stt_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       ch_valid;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [23:0] start_offset;
      logic [23:0] lexeme_length;
      logic [15:0] line_number;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      M_NORMAL, M_OP, M_SLASH, M_LINE, M_BLOCK, M_BSLASH, M_BSTAR,
      M_STR, M_ESC, M_INT, M_DOT, M_FRAC, M_IDENT
   } mode_type;

   localparam logic [5:0] K_DOT    = 6'd5;
   localparam logic [5:0] K_STAR   = 6'd10;
   localparam logic [5:0] K_SLASH  = 6'd9;
   localparam logic [5:0] K_IDENT  = 6'd19;
   localparam logic [5:0] K_STRING = 6'd20;
   localparam logic [5:0] K_NUMBER = 6'd21;
   localparam logic [5:0] K_KW0    = 6'd22;
   localparam logic [5:0] K_END    = 6'd38;

   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_UNEXP   = 3'd1;
   localparam logic [2:0] E_ESCAPE  = 3'd2;
   localparam logic [2:0] E_NEWLINE = 3'd3;
   localparam logic [2:0] E_UNTSTR  = 3'd4;
   localparam logic [2:0] E_UNTCOM  = 3'd5;

   localparam int MAX_RES = 4;

   // One token as produced by the scanner, before output formatting.
   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [31:0] start;
      logic [31:0] len;
   } tok_type;

   // Tokens below split carry line0 (before the newline), the rest carry line.
   typedef struct packed {
      tok_type [MAX_RES-1:0] tok;
      logic [2:0]            count;
      logic [31:0]           line;
      logic [31:0]           line0;
      logic [2:0]            split;
   } batch_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] c, input logic eq);
      logic [5:0] b;
      b = (c == "!") ? 6'd11 : (c == "=") ? 6'd13 : (c == ">") ? 6'd15 : 6'd17;
      return b + {5'd0, eq};
   endfunction

   function automatic logic [5:0] word_kind(input logic [47:0] p, input logic [2:0] n);
      logic [5:0] k;
      k = K_IDENT;
      case ({n, p})
         {3'd3, 24'd0, "and"}:    k = K_KW0 + 6'd0;
         {3'd5, 8'd0, "class"}:   k = K_KW0 + 6'd1;
         {3'd4, 16'd0, "else"}:   k = K_KW0 + 6'd2;
         {3'd5, 8'd0, "false"}:   k = K_KW0 + 6'd3;
         {3'd3, 24'd0, "fun"}:    k = K_KW0 + 6'd4;
         {3'd3, 24'd0, "for"}:    k = K_KW0 + 6'd5;
         {3'd2, 32'd0, "if"}:     k = K_KW0 + 6'd6;
         {3'd3, 24'd0, "nil"}:    k = K_KW0 + 6'd7;
         {3'd2, 32'd0, "or"}:     k = K_KW0 + 6'd8;
         {3'd5, 8'd0, "print"}:   k = K_KW0 + 6'd9;
         {3'd6, "return"}:        k = K_KW0 + 6'd10;
         {3'd5, 8'd0, "super"}:   k = K_KW0 + 6'd11;
         {3'd4, 16'd0, "this"}:   k = K_KW0 + 6'd12;
         {3'd4, 16'd0, "true"}:   k = K_KW0 + 6'd13;
         {3'd3, 24'd0, "var"}:    k = K_KW0 + 6'd14;
         {3'd5, 8'd0, "while"}:   k = K_KW0 + 6'd15;
         default:                 k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage

[hdl/source_text_tokenizer.sv]
// ---------------------------------------------------------------------------
// Source text tokeniser
// Streams source bytes in and lexical tokens out through queue ports.
// ---------------------------------------------------------------------------
//  channel   ports                          transaction when
//  request   req_push req_full req_item     req_push && !req_full
//  response  rsp_pop rsp_empty rsp_item     rsp_pop && !rsp_empty
//
// One byte is scanned per cycle while req_full is low; the scanner loop is combinational.
// Tokens pass through the scanner output register and the batch queue to the response ports
// and leave one per pop, so a byte making several tokens takes that many pops.
// req_full rises when the batch queue is nearly full. Reset is synchronous.
module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 16,
   parameter int MAX_NEST    = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_item,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_item
);

   logic      acc, bv;
   batch_type bat;

   assign acc = req_push && !req_full;

   stt_scanner #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .MAX_NEST(MAX_NEST))
   u_scan (
      .clock(clock), .reset(reset), .in_valid(acc), .in_item(req_item),
      .out_valid(bv), .out_batch(bat)
   );

   stt_emitter #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_emit (
      .clock(clock), .reset(reset), .in_valid(bv), .in_batch(bat),
      .almost_full(req_full), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

`ifndef SYNTHESIS
   a_batch_nonempty: assert property (@(posedge clock) disable iff (reset)
      bv |-> bat.count != 3'd0) else $error("empty batch queued");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.token_kind == K_END) |-> rsp_item.last_of_run)
      else $error("end token not last");
   a_err_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.error_code != E_NONE) |-> rsp_item.lexeme_length == 24'd0)
      else $error("error with length");
`endif

endmodule

[hdl/stt_scanner.sv]
// ---------------------------------------------------------------------------
// Tokeniser front end
// Scans one byte per cycle and produces a batch of up to four tokens.
// ---------------------------------------------------------------------------
module stt_scanner
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 16,
   parameter int MAX_NEST    = 255
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_item,
   output logic      out_valid,
   output batch_type out_batch
);

   localparam int NEST_BITS = $clog2(MAX_NEST + 1);
   localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
   localparam logic [NEST_BITS-1:0]   NMAX = NEST_BITS'(MAX_NEST);

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [NEST_BITS-1:0]   depth_ff, depth_in;
   logic [47:0]            pfx_ff, pfx_in;
   logic [2:0]             wlen_ff, wlen_in;
   logic [7:0]             held_ff, held_in;
   logic                   ov_in;
   batch_type              bat_in;

   always_comb begin
      logic [7:0] c;
      logic       again, flush;
      logic [2:0] n;
      c       = in_item.ch;
      mode_in = mode_ff; pos_in = pos_ff; start_in = start_ff; line_in = line_ff;
      depth_in = depth_ff; pfx_in = pfx_ff; wlen_in = wlen_ff; held_in = held_ff;
      n = '0;
      again = 1'b0;
      bat_in = '0;
      flush = in_valid && in_item.end_of_source;

      // Emit helper via inline sequence; tokens fill slots in order.
      if (in_valid && in_item.ch_valid) begin
         again = 1'b1;
         // At most two passes: a pending lexeme closes, then the byte restarts.
         for (int pass = 0; pass < 2; pass++) begin
            if (again) begin
               again = 1'b0;
               unique case (mode_in)
                  M_OP: begin
                     mode_in = M_NORMAL;
                     if (c == "=") begin
                        bat_in.tok[n[1:0]] = {op_kind(held_in, 1'b1), E_NONE,
                           32'(start_in), 32'd2};
                        n = n + 3'd1;
                     end else begin
                        bat_in.tok[n[1:0]] = {op_kind(held_in, 1'b0), E_NONE,
                           32'(start_in), 32'd1};
                        n = n + 3'd1; again = 1'b1;
                     end
                  end
                  M_SLASH: begin
                     if (c == "/") mode_in = M_LINE;
                     else if (c == "*") begin
                        mode_in = M_BLOCK; depth_in = NEST_BITS'(1);
                     end else begin
                        bat_in.tok[n[1:0]] = {K_SLASH, E_NONE, 32'(start_in), 32'd1};
                        n = n + 3'd1; mode_in = M_NORMAL; again = 1'b1;
                     end
                  end
                  M_LINE: begin
                     if (c == 8'h0a) begin
                        if (line_in < LMAX) line_in = line_in + 1'b1;
                        bat_in.split = n;
                        mode_in = M_NORMAL;
                     end
                  end
                  M_BLOCK: begin
                     if (c == "/") mode_in = M_BSLASH;
                     else if (c == "*") mode_in = M_BSTAR;
                     else if (c == 8'h0a) begin
                        if (line_in < LMAX) line_in = line_in + 1'b1;
                        bat_in.split = n;
                     end
                  end
                  M_BSLASH: begin
                     mode_in = M_BLOCK;
                     if (c == "*") begin
                        if (depth_in < NMAX) depth_in = depth_in + 1'b1;
                     end else again = 1'b1;
                  end
                  M_BSTAR: begin
                     if (c == "/") begin
                        if (depth_in <= NEST_BITS'(1)) begin
                           depth_in = '0; mode_in = M_NORMAL;
                        end else begin
                           depth_in = depth_in - 1'b1; mode_in = M_BLOCK;
                        end
                     end else begin
                        mode_in = M_BLOCK; again = 1'b1;
                     end
                  end
                  M_STR: begin
                     if (c == 8'h22) begin
                        bat_in.tok[n[1:0]] = {K_STRING, E_NONE, 32'(start_in),
                           32'(OFFSET_BITS'(pos_in + 1'b1 - start_in))};
                        n = n + 3'd1; mode_in = M_NORMAL;
                     end else if (c == 8'h5c) mode_in = M_ESC;
                     else if (c == 8'h0a) begin
                        if (line_in < LMAX) line_in = line_in + 1'b1;
                        bat_in.split = n;
                        bat_in.tok[n[1:0]] = {6'd0, E_NEWLINE, 32'(start_in), 32'd0};
                        n = n + 3'd1; mode_in = M_NORMAL;
                     end
                  end
                  M_ESC: begin
                     if (c == "n" || c == "t" || c == "r" || c == 8'h22 || c == 8'h5c)
                        mode_in = M_STR;
                     else begin
                        bat_in.tok[n[1:0]] = {6'd0, E_ESCAPE, 32'(start_in), 32'd0};
                        n = n + 3'd1; mode_in = M_NORMAL;
                     end
                  end
                  M_INT, M_FRAC: begin
                     if (is_digit(c)) begin
                     end else if (c == "." && mode_in == M_INT) mode_in = M_DOT;
                     else begin
                        bat_in.tok[n[1:0]] = {K_NUMBER, E_NONE, 32'(start_in),
                           32'(OFFSET_BITS'(pos_in - start_in))};
                        n = n + 3'd1; mode_in = M_NORMAL; again = 1'b1;
                     end
                  end
                  M_DOT: begin
                     if (is_digit(c)) mode_in = M_FRAC;
                     else begin
                        bat_in.tok[n[1:0]] = {K_NUMBER, E_NONE, 32'(start_in),
                           32'(OFFSET_BITS'(pos_in - 1'b1 - start_in))};
                        n = n + 3'd1;
                        bat_in.tok[n[1:0]] = {K_DOT, E_NONE,
                           32'(OFFSET_BITS'(pos_in - 1'b1)), 32'd1};
                        n = n + 3'd1; mode_in = M_NORMAL; again = 1'b1;
                     end
                  end
                  M_IDENT: begin
                     if (is_alpha(c) || is_digit(c)) begin
                        if (wlen_in < 3'd6) pfx_in = {pfx_in[39:0], c};
                        if (wlen_in < 3'd7) wlen_in = wlen_in + 3'd1;
                     end else begin
                        bat_in.tok[n[1:0]] = {
                           (wlen_in <= 3'd6) ? word_kind(pfx_in, wlen_in) : K_IDENT,
                           E_NONE, 32'(start_in), 32'(OFFSET_BITS'(pos_in - start_in))};
                        n = n + 3'd1; mode_in = M_NORMAL; again = 1'b1;
                     end
                  end
                  default: begin
                     mode_in = M_NORMAL; start_in = pos_in;
                     case (c)
                        "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
                           bat_in.tok[n[1:0]].kind =
                              (c == "(") ? 6'd0 : (c == ")") ? 6'd1 : (c == "{") ? 6'd2 :
                              (c == "}") ? 6'd3 : (c == ",") ? 6'd4 : (c == ".") ? 6'd5 :
                              (c == "-") ? 6'd6 : (c == "+") ? 6'd7 : (c == ";") ? 6'd8 :
                              K_STAR;
                           bat_in.tok[n[1:0]].err   = E_NONE;
                           bat_in.tok[n[1:0]].start = 32'(pos_in);
                           bat_in.tok[n[1:0]].len   = 32'd1;
                           n = n + 3'd1;
                        end
                        "!", "=", "<", ">": begin held_in = c; mode_in = M_OP; end
                        "/": mode_in = M_SLASH;
                        8'h22: mode_in = M_STR;
                        " ", 8'h0d, 8'h09: ;
                        8'h0a: begin
                           if (line_in < LMAX) line_in = line_in + 1'b1;
                           bat_in.split = n;
                        end
                        default: begin
                           if (is_digit(c)) mode_in = M_INT;
                           else if (is_alpha(c)) begin
                              pfx_in = {40'd0, c}; wlen_in = 3'd1; mode_in = M_IDENT;
                           end else begin
                              bat_in.tok[n[1:0]] = {6'd0, E_UNEXP, 32'(pos_in), 32'd0};
                              n = n + 3'd1;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         pos_in = pos_in + 1'b1;
      end

      if (flush) begin
         unique case (mode_in)
            M_OP: begin
               bat_in.tok[n[1:0]] = {op_kind(held_in, 1'b0), E_NONE, 32'(start_in), 32'd1};
               n = n + 3'd1;
            end
            M_SLASH: begin
               bat_in.tok[n[1:0]] = {K_SLASH, E_NONE, 32'(start_in), 32'd1};
               n = n + 3'd1;
            end
            M_BLOCK, M_BSLASH, M_BSTAR: begin
               bat_in.tok[n[1:0]] = {6'd0, E_UNTCOM, 32'(start_in), 32'd0};
               n = n + 3'd1;
            end
            M_STR, M_ESC: begin
               bat_in.tok[n[1:0]] = {6'd0, E_UNTSTR, 32'(start_in), 32'd0};
               n = n + 3'd1;
            end
            M_INT, M_FRAC: begin
               bat_in.tok[n[1:0]] = {K_NUMBER, E_NONE, 32'(start_in),
                  32'(OFFSET_BITS'(pos_in - start_in))};
               n = n + 3'd1;
            end
            M_DOT: begin
               bat_in.tok[n[1:0]] = {K_NUMBER, E_NONE, 32'(start_in),
                  32'(OFFSET_BITS'(pos_in - 1'b1 - start_in))};
               n = n + 3'd1;
               bat_in.tok[n[1:0]] = {K_DOT, E_NONE, 32'(OFFSET_BITS'(pos_in - 1'b1)), 32'd1};
               n = n + 3'd1;
            end
            M_IDENT: begin
               bat_in.tok[n[1:0]] = {
                  (wlen_in <= 3'd6) ? word_kind(pfx_in, wlen_in) : K_IDENT,
                  E_NONE, 32'(start_in), 32'(OFFSET_BITS'(pos_in - start_in))};
               n = n + 3'd1;
            end
            default: ;
         endcase
         bat_in.tok[n[1:0]] = {K_END, E_NONE, 32'(pos_in), 32'd0};
         n = n + 3'd1;
      end
      bat_in.count = n;
      bat_in.line  = 32'(line_in);
      bat_in.line0 = 32'(line_ff);
      ov_in = n != 3'd0;
      if (flush) begin
         mode_in = M_NORMAL; pos_in = '0; start_in = '0; line_in = LINE_BITS'(1);
         depth_in = '0; pfx_in = '0; wlen_in = '0; held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL; pos_ff <= '0; start_ff <= '0; line_ff <= LINE_BITS'(1);
         depth_ff <= '0; pfx_ff <= '0; wlen_ff <= '0; held_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         mode_ff <= mode_in; pos_ff <= pos_in; start_ff <= start_in; line_ff <= line_in;
         depth_ff <= depth_in; pfx_ff <= pfx_in; wlen_ff <= wlen_in; held_ff <= held_in;
         out_valid <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      out_batch <= bat_in;
   end

endmodule

[hdl/stt_emitter.sv]
// ---------------------------------------------------------------------------
// Tokeniser back end
// Queues token batches and hands out one token per pop.
// ---------------------------------------------------------------------------
module stt_emitter
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  batch_type in_batch,
   output logic      almost_full,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_item
);

   localparam int DEPTH = 4;

   batch_type       q_ff [DEPTH];
   logic [1:0]      wp_ff, rp_ff;
   logic [2:0]      cnt_ff;
   logic [1:0]      sub_ff;
   logic            take, done;
   tok_type         t;
   batch_type       head;

   assign head      = q_ff[rp_ff];
   assign t         = head.tok[sub_ff];
   assign rsp_empty = cnt_ff == 3'd0;
   assign take      = rsp_pop && !rsp_empty;
   assign done      = take && ({1'b0, sub_ff} + 3'd1 == head.count);
   // Leave room for the batch in flight in the front register.
   assign almost_full = cnt_ff >= 3'(DEPTH - 2);

   assign rsp_item.token_kind    = t.kind;
   assign rsp_item.error_code    = t.err;
   assign rsp_item.start_offset  = 24'(t.start[OFFSET_BITS-1:0]);
   assign rsp_item.lexeme_length = 24'(t.len[OFFSET_BITS-1:0]);
   assign rsp_item.line_number   = 16'(({1'b0, sub_ff} < head.split) ?
                                       head.line0[LINE_BITS-1:0] :
                                       head.line[LINE_BITS-1:0]);
   assign rsp_item.last_of_run   = {1'b0, sub_ff} + 3'd1 == head.count;

   always_ff @(posedge clock) begin
      if (in_valid) q_ff[wp_ff] <= in_batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; sub_ff <= '0;
      end else begin
         if (in_valid) wp_ff <= wp_ff + 2'd1;
         if (done) begin
            rp_ff <= rp_ff + 2'd1; sub_ff <= '0;
         end else if (take) sub_ff <= sub_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, in_valid} - {2'd0, done};
      end
   end

endmodule

[sim/source_text_tokenizer_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tokeniser checker
// Watches both queue ports, predicts the tokens of every accepted byte and
// compares each popped token field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module source_text_tokenizer_checker
   import stt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_item,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_tokens,
   output int      token_total
);

   localparam logic [23:0] OFS_MASK = 24'hFFFFFF;
   localparam logic [15:0] LINE_SAT = 16'hFFFF;
   localparam int          NEST_SAT = 255;

   rsp_type     token_queue[$];
   mode_type    mode;
   logic [23:0] pos;
   logic [23:0] tok_start;
   logic [15:0] line_cnt;
   int          depth;
   logic [47:0] prefix;
   int          word_len;
   logic [7:0]  held;
   rsp_type     run[$];

   assign pending_tokens = token_queue.size();

   function automatic bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [5:0] relop_kind(logic [7:0] c, bit eq);
      logic [5:0] b;
      b = (c == "!") ? 6'd11 : (c == "=") ? 6'd13 : (c == ">") ? 6'd15 : 6'd17;
      return b + (eq ? 6'd1 : 6'd0);
   endfunction

   task automatic add_token(logic [5:0] kind, logic [2:0] err, logic [23:0] st,
                            logic [23:0] len);
      rsp_type t;
      if (run.size() >= MAX_RES) return;
      t.token_kind = kind;
      t.error_code = err;
      t.start_offset = st;
      t.lexeme_length = len;
      t.line_number = line_cnt;
      t.last_of_run = 1'b0;
      run.insert(run.size(), t);
   endtask

   task automatic bump_line();
      if (line_cnt < LINE_SAT) line_cnt++;
   endtask

   task automatic close_word(logic [23:0] stop);
      string       words[16];
      logic [5:0]  kind;
      logic [47:0] p;
      words = '{"and", "class", "else", "false", "fun", "for", "if", "nil",
                "or", "print", "return", "super", "this", "true", "var", "while"};
      kind = K_IDENT;
      if (word_len <= 6) begin
         for (int i = 0; i < 16; i++) begin
            p = '0;
            for (int j = 0; j < words[i].len(); j++) p = (p << 8) | 48'(words[i][j]);
            if (words[i].len() == word_len && p == prefix) begin
               kind = K_KW0 + 6'(i);
               break;
            end
         end
      end
      add_token(kind, E_NONE, tok_start, stop - tok_start);
   endtask

   task automatic open_lexeme(logic [7:0] c);
      string singles;
      singles = "(){},.-+;";
      tok_start = pos;
      for (int i = 0; i < 9; i++) begin
         if (singles[i] == c) begin
            add_token(6'(i), E_NONE, pos, 24'd1);
            return;
         end
      end
      if (c == "*") add_token(K_STAR, E_NONE, pos, 24'd1);
      else if (c == "!" || c == "=" || c == "<" || c == ">") begin
         held = c;
         mode = M_OP;
      end else if (c == "/") mode = M_SLASH;
      else if (c == "\"") mode = M_STR;
      else if (c == " " || c == 8'h0D || c == 8'h09) ;
      else if (c == 8'h0A) bump_line();
      else if (digit_c(c)) mode = M_INT;
      else if (alpha_c(c)) begin
         prefix = {40'd0, c};
         word_len = 1;
         mode = M_IDENT;
      end else add_token(6'd0, E_UNEXP, pos, 24'd0);
   endtask

   task automatic scan(logic [7:0] c);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (mode)
            M_OP: begin
               mode = M_NORMAL;
               if (c == "=") add_token(relop_kind(held, 1), E_NONE, tok_start, 24'd2);
               else begin
                  add_token(relop_kind(held, 0), E_NONE, tok_start, 24'd1);
                  again = 1;
               end
            end
            M_SLASH: begin
               if (c == "/") mode = M_LINE;
               else if (c == "*") begin
                  mode = M_BLOCK;
                  depth = 1;
               end else begin
                  add_token(K_SLASH, E_NONE, tok_start, 24'd1);
                  mode = M_NORMAL;
                  again = 1;
               end
            end
            M_LINE: if (c == 8'h0A) begin
               bump_line();
               mode = M_NORMAL;
            end
            M_BLOCK: begin
               if (c == "/") mode = M_BSLASH;
               else if (c == "*") mode = M_BSTAR;
               else if (c == 8'h0A) bump_line();
            end
            M_BSLASH: begin
               mode = M_BLOCK;
               if (c == "*") begin
                  if (depth < NEST_SAT) depth++;
               end else again = 1;
            end
            M_BSTAR: begin
               if (c == "/") begin
                  if (depth <= 1) begin
                     depth = 0;
                     mode = M_NORMAL;
                  end else begin
                     depth--;
                     mode = M_BLOCK;
                  end
               end else begin
                  mode = M_BLOCK;
                  again = 1;
               end
            end
            M_STR: begin
               if (c == "\"") begin
                  add_token(K_STRING, E_NONE, tok_start, pos + 24'd1 - tok_start);
                  mode = M_NORMAL;
               end else if (c == "\\") mode = M_ESC;
               else if (c == 8'h0A) begin
                  bump_line();
                  add_token(6'd0, E_NEWLINE, tok_start, 24'd0);
                  mode = M_NORMAL;
               end
            end
            M_ESC: begin
               if (c == "n" || c == "t" || c == "r" || c == "\"" || c == "\\")
                  mode = M_STR;
               else begin
                  add_token(6'd0, E_ESCAPE, tok_start, 24'd0);
                  mode = M_NORMAL;
               end
            end
            M_INT, M_FRAC: begin
               if (c == "." && mode == M_INT) mode = M_DOT;
               else if (!digit_c(c)) begin
                  add_token(K_NUMBER, E_NONE, tok_start, pos - tok_start);
                  mode = M_NORMAL;
                  again = 1;
               end
            end
            M_DOT: begin
               if (digit_c(c)) mode = M_FRAC;
               else begin
                  add_token(K_NUMBER, E_NONE, tok_start, pos - 24'd1 - tok_start);
                  add_token(K_DOT, E_NONE, pos - 24'd1, 24'd1);
                  mode = M_NORMAL;
                  again = 1;
               end
            end
            M_IDENT: begin
               if (alpha_c(c) || digit_c(c)) begin
                  if (word_len < 6) prefix = (prefix << 8) | c;
                  if (word_len < 7) word_len++;
               end else begin
                  close_word(pos);
                  mode = M_NORMAL;
                  again = 1;
               end
            end
            default: begin
               mode = M_NORMAL;
               open_lexeme(c);
            end
         endcase
      end
   endtask

   task automatic flush_source();
      case (mode)
         M_OP: add_token(relop_kind(held, 0), E_NONE, tok_start, 24'd1);
         M_SLASH: add_token(K_SLASH, E_NONE, tok_start, 24'd1);
         M_BLOCK, M_BSLASH, M_BSTAR: add_token(6'd0, E_UNTCOM, tok_start, 24'd0);
         M_STR, M_ESC: add_token(6'd0, E_UNTSTR, tok_start, 24'd0);
         M_INT, M_FRAC: add_token(K_NUMBER, E_NONE, tok_start, pos - tok_start);
         M_DOT: begin
            add_token(K_NUMBER, E_NONE, tok_start, pos - 24'd1 - tok_start);
            add_token(K_DOT, E_NONE, pos - 24'd1, 24'd1);
         end
         M_IDENT: close_word(pos);
         default: ;
      endcase
      add_token(K_END, E_NONE, pos, 24'd0);
   endtask

   task automatic clear_scanner();
      mode = M_NORMAL;
      pos = '0;
      tok_start = '0;
      line_cnt = 16'd1;
      depth = 0;
      prefix = '0;
      word_len = 0;
      held = '0;
   endtask

   task automatic predict(req_type r);
      run.delete();
      if (r.ch_valid) begin
         scan(r.ch);
         pos = (pos + 24'd1) & OFS_MASK;
      end
      if (r.end_of_source) begin
         flush_source();
         clear_scanner();
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) token_queue.insert(token_queue.size(), run[i]);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_scanner();
         token_queue.delete();
         fail_count <= 0;
         token_total <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            token_total <= token_total + 1;
            if (token_queue.size() == 0) begin
               $display("%0t: unexpected token: expected none, actual %p", $realtime,
                        rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = token_queue.pop_front();
               if (rsp_item !== want) begin
                  $display("%0t: token mismatch: expected %p, actual %p", $realtime, want,
                           rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_push && !req_full) predict(req_item);
      end
   end

endmodule

[sim/source_text_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tokeniser testbench
// Feeds directed and random source texts byte by byte with random gaps and
// pop stalls, including one long pop hold-off; the checker does the compare.
// ---------------------------------------------------------------------------
module source_text_tokenizer_tb;
   import stt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_item = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_tokens;
   int      token_total;
   int      cycle_count = 0;
   int      items_sent = 0;
   bit      calm = 0;
   bit      hold_off = 0;
   req_type src[$];

   always #2 clock = ~clock;

   source_text_tokenizer u_top (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_item(req_item), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

   source_text_tokenizer_checker u_checker (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_item(req_item), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_item(rsp_item), .fail_count(fail_count),
      .pending_tokens(pending_tokens), .token_total(token_total)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("source_text_tokenizer_tb failed");
         $finish;
      end
   end

   // Receiver: random stalls, none while calm, nothing during the hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= calm || ($urandom_range(99) >= 16);
   end

   task automatic add_text(string s, bit close);
      req_type r;
      foreach (s[i]) begin
         r.ch = s[i];
         r.ch_valid = 1'b1;
         r.end_of_source = close && (i == s.len() - 1);
         src.insert(src.size(), r);
      end
   endtask

   task automatic add_raw(logic [7:0] c, bit v, bit e);
      req_type r;
      r.ch = c;
      r.ch_valid = v;
      r.end_of_source = e;
      src.insert(src.size(), r);
   endtask

   task automatic add_random_source();
      string frags[24];
      int    n;
      frags = '{"and ", "class ", "else", "false", "fun(", "for ", "if(", "nil;",
                "or ", "print ", "return ", "super.", "this,", "true}", "var x=",
                "while{", "12.5 ", "7.", "a_b9 ", "\"s\\t\" ", "// c\n", "/* /* */ */",
                "!=<=>===", "\n"};
      n = $urandom_range(8, 2);
      repeat (n) begin
         if ($urandom_range(9) == 0) add_raw(8'($urandom), 1'b1, 1'b0);
         else if ($urandom_range(19) == 0) add_raw(8'($urandom), 1'b0, 1'b0);
         else add_text(frags[$urandom_range(23)], 0);
      end
      add_raw(8'($urandom), 1'($urandom), 1'b1);
   endtask

   // Sender: drains src with random gaps; push stays high while req_full holds an item.
   task automatic send_all();
      while (src.size() > 0) begin
         if (!calm && $urandom_range(99) < 16) begin
            req_push <= 1'b0;
            @(posedge clock);
         end else begin
            req_push <= 1'b1;
            req_item <= src[0];
            @(posedge clock);
            while (req_full) @(posedge clock);
            void'(src.pop_front());
            items_sent++;
         end
      end
      req_push <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: operators, words, numbers, strings and every error path
      add_text("(){},.-+;*! != = == > >= < <= / ", 0);
      add_raw(8'hFF, 1'b1, 1'b0);
      add_raw(8'h00, 1'b0, 1'b0);
      add_text("returns 3.", 1);
      add_text("\"a\\q\"\n\"b\n\"c\\", 1);
      add_text("/*x", 1);
      add_raw(8'h00, 1'b0, 1'b1);
      add_text("\"\\\"", 1);
      send_all();
      calm = 1;
      repeat (3) add_random_source();
      send_all();
      calm = 0;
      // long hold-off while bytes keep coming, to fill the output queue
      hold_off = 1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         begin
            repeat (4) add_text("(((((", 0);
            add_raw(8'h00, 1'b0, 1'b1);
            send_all();
         end
      join
      while (items_sent < 180) begin
         add_random_source();
         send_all();
      end
      while (pending_tokens != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d source items, checked %0d tokens including all error kinds",
               items_sent, token_total);
      if (fail_count == 0 && pending_tokens == 0) begin
         $display("source_text_tokenizer_tb passed");
      end else begin
         $display("source_text_tokenizer_tb failed");
      end
      $finish;
   end

endmodule
